>>> src/bat_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helper functions for the buddy allocator tree
// no dependencies; imported by bat_ctrl, buddy_allocator_tree_core and the testbench
`default_nettype none

package bat_pkg;

	localparam int MAX_LEAVES_DEF = 1024;
	localparam int MAX_LEVELS_DEF = 11;

	// width of an order computed from a 32 bit size (up to 33)
	localparam int ORD_W = 6;

	// configuration register indexes
	localparam logic [1:0] REG_REGION_BYTES = 2'd0;
	localparam logic [1:0] REG_BASE_ORDER   = 2'd1;
	localparam logic [1:0] REG_REGION_BASE  = 2'd2;

	localparam logic [31:0] RST_REGION_BYTES = 32'd65536;
	localparam logic [4:0]  RST_BASE_ORDER   = 5'd6;
	localparam logic [31:0] RST_REGION_BASE  = 32'd0;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_ALIGN = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ORD_WAIT,
		S_CLR_START,
		S_CLR_LV,
		S_CLR_BLK,
		S_CLR_RSTART,
		S_CLR_RWAIT,
		S_CLR_SWEEP,
		S_A_ROOT,
		S_A_ROOTCHK,
		S_A_DRD,
		S_A_DDEC,
		S_A_OFF,
		S_A_CHK,
		S_A_URD,
		S_A_UDEC,
		S_F_IDX,
		S_F_CHK,
		S_F_RD,
		S_F_DEC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] region_bytes;
		logic [4:0]  base_order;
		logic [31:0] region_base;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] num_bytes;
		logic [31:0] align;
		logic [31:0] offset;
	} item_t;

	typedef struct packed {
		logic [31:0] block_offset;
		status_t     status;
	} res_t;

	// order of a size from the bit length of size minus one
	function automatic logic [ORD_W-1:0] order_of(input logic [5:0] bw, input logic [4:0] bo);
		logic [ORD_W-1:0] o;
		if (bw <= {1'b0, bo})
			o = ORD_W'(1);
		else
			o = ORD_W'(bw - {1'b0, bo} + 6'd1);
		return o;
	endfunction

	// largest root order whose bottom level still fits the leaves
	function automatic int level_limit(input int max_levels, input int max_leaves);
		int l;
		l = max_levels;
		while (l > 1 && (64'd1 << (l - 1)) > 64'(max_leaves))
			l = l - 1;
		return l;
	endfunction

endpackage

`default_nettype wire

>>> src/bat_ram.sv
`timescale 1ns / 1ps
// generic ram, one write port and two read ports with registered read data
// no dependencies
`default_nettype none

module bat_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2048
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]        rdata_a,
	input  wire [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]        rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

>>> src/bat_bitlen.sv
`timescale 1ns / 1ps
// bit length unit: scans a 32 bit word one byte a cycle from the top
// no dependencies; used by the sequencer for every order and remainder
`default_nettype none

module bat_bitlen (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [31:0] operand,
	output logic        done,
	output logic [5:0]  len
);

	logic [31:0] op_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        found_q;
	logic [5:0]  len_q;
	logic        done_q;
	logic [7:0]  top_byte;

	function automatic logic [3:0] bl8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++)
			if (b[k])
				n = 4'(k + 1);
		return n;
	endfunction

	assign top_byte = op_q[31:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd0);
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && cnt_q == 2'd0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= operand;
			cnt_q   <= 2'd3;
			found_q <= 1'b0;
			len_q   <= 6'd0;
		end else if (busy_q) begin
			op_q  <= {op_q[23:0], 8'd0};
			cnt_q <= cnt_q - 2'd1;
			if (!found_q && top_byte != 8'd0) begin
				found_q <= 1'b1;
				len_q   <= 6'({cnt_q, 3'b000}) + 6'(bl8(top_byte));
			end
		end
	end

	assign done = done_q;
	assign len  = len_q;

endmodule

`default_nettype wire

>>> src/bat_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the buddy allocator: clear sweep, allocate descent and
// climb, free merge; uses bat_pkg, bat_ram and bat_bitlen
`default_nettype none

module bat_ctrl import bat_pkg::*; #(
	parameter int MAX_LEAVES = MAX_LEAVES_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  cfg_t        cfg,
	input  wire         in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        res_valid,
	input  wire         res_ready,
	output res_t        res
);

	localparam int TREE_SIZE = 2 * MAX_LEAVES;
	localparam int NODE_W    = $clog2(TREE_SIZE);
	localparam int CAP_W     = $clog2(MAX_LEVELS + 1);
	localparam int LIM       = level_limit(MAX_LEVELS, MAX_LEAVES);

	state_t state_q, state_d;

	item_t            item_q;
	logic             from_item_q;
	logic [ORD_W-1:0] req_q;
	logic [CAP_W-1:0] lv_q;
	logic [NODE_W-1:0] block_q;
	logic [CAP_W-1:0] ord_q;
	logic [CAP_W-1:0] cap_q;
	logic [31:0]      off_q;
	logic [31:0]      idx_q;
	status_t          status_q;
	logic [31:0]      boff_q;
	// clear sweep
	logic [4:0]       cbo_q;
	logic [31:0]      sh_q;
	logic [NODE_W-1:0] blocks_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] i_q;
	logic [CAP_W-1:0] o_q;
	logic             act_q;
	logic [CAP_W-1:0] r_q;
	logic [NODE_W-1:0] full_q;

	// ram and bit length unit
	logic              ram_we;
	logic [NODE_W-1:0] ram_waddr;
	logic [CAP_W-1:0]  ram_wdata;
	logic [NODE_W-1:0] ram_raddr_a, ram_raddr_b;
	logic [CAP_W-1:0]  ram_rdata_a, ram_rdata_b;
	logic              bl_start;
	logic [31:0]       bl_operand;
	logic              bl_done;
	logic [5:0]        bl_len;

	// decisions
	logic [ORD_W-1:0]  lv_ext;
	logic [ORD_W-1:0]  item_ord;
	logic [ORD_W-1:0]  clr_ord;
	logic [CAP_W-1:0]  clr_lv;
	logic [31:0]       lv_pow;
	logic [NODE_W-1:0] l_idx;
	logic              go_right;
	logic [NODE_W-1:0] desc_block;
	logic [CAP_W-1:0]  req_c;
	logic [NODE_W-1:0] blk_in_lvl;
	logic [6:0]        sh_amt;
	logic [31:0]       abs_addr;
	logic              align_bad;
	logic [CAP_W-1:0]  climb_cap;
	logic [CAP_W-1:0]  ord_inc;
	logic [31:0]       free_lim;
	logic [NODE_W-1:0] free_block;
	logic              buddy_ge;
	logic [CAP_W-1:0]  merge_cap;
	logic [CAP_W-1:0]  clr_val;
	logic              sweep_end;
	logic              lvl_last;

	bat_ram #(
		.WIDTH (CAP_W),
		.DEPTH (TREE_SIZE)
	) u_tree (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	bat_bitlen u_bitlen (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (bl_start),
		.operand (bl_operand),
		.done    (bl_done),
		.len     (bl_len)
	);

	always_comb begin
		lv_ext     = ORD_W'(lv_q);
		req_c      = req_q[CAP_W-1:0];
		item_ord   = order_of(bl_len, cfg.base_order);
		clr_ord    = order_of(bl_len, cbo_q);
		clr_lv     = (clr_ord > ORD_W'(LIM)) ? CAP_W'(LIM) : clr_ord[CAP_W-1:0];
		lv_pow     = 32'd1 << (lv_q - CAP_W'(1));
		// descent prefers the smaller sufficient child
		l_idx      = {block_q[NODE_W-2:0], 1'b0};
		if (ram_rdata_a < ram_rdata_b)
			go_right = ORD_W'(ram_rdata_a) < req_q;
		else
			go_right = ORD_W'(ram_rdata_b) >= req_q;
		desc_block = l_idx | NODE_W'(go_right);
		blk_in_lvl = block_q & ~(NODE_W'(1) << (lv_q - req_c));
		sh_amt     = 7'(cfg.base_order) + 7'(req_q) - 7'd1;
		abs_addr   = cfg.region_base + off_q;
		align_bad  = (abs_addr & (item_q.align - 32'd1)) != 32'd0;
		climb_cap  = (ram_rdata_a > cap_q) ? ram_rdata_a : cap_q;
		ord_inc    = ord_q + CAP_W'(1);
		free_lim   = 32'd1 << (lv_q - req_c);
		free_block = free_lim[NODE_W-1:0] | idx_q[NODE_W-1:0];
		buddy_ge   = ram_rdata_a >= cap_q;
		merge_cap  = buddy_ge ? cap_q + CAP_W'(1) : cap_q;
		// free layout of one node during the clear sweep
		if (!act_q)
			clr_val = '0;
		else if (i_q < full_q)
			clr_val = o_q;
		else if (i_q == full_q)
			clr_val = r_q;
		else
			clr_val = '0;
		sweep_end  = node_q == NODE_W'(TREE_SIZE - 1);
		lvl_last   = (node_q & (node_q + NODE_W'(1))) == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR_START;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		bl_start    = 1'b0;
		bl_operand  = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_item.mode)
						MODE_CLEAR: state_d = S_CLR_START;
						MODE_ALLOC, MODE_FREE: begin
							bl_start   = 1'b1;
							bl_operand = in_item.num_bytes - 32'd1;
							state_d    = S_ORD_WAIT;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ORD_WAIT: begin
				if (bl_done)
					state_d = (item_q.mode == MODE_ALLOC) ? S_A_ROOT : S_F_IDX;
			end
			S_CLR_START: begin
				bl_start   = 1'b1;
				bl_operand = cfg.region_bytes - 32'd1;
				state_d    = S_CLR_LV;
			end
			S_CLR_LV: begin
				if (bl_done)
					state_d = S_CLR_BLK;
			end
			S_CLR_BLK: state_d = S_CLR_RSTART;
			S_CLR_RSTART: begin
				bl_start = 1'b1;
				if (act_q)
					bl_operand = 32'(blocks_q) & ((32'd1 << (o_q - CAP_W'(1))) - 32'd1);
				state_d = S_CLR_RWAIT;
			end
			S_CLR_RWAIT: begin
				if (bl_done)
					state_d = S_CLR_SWEEP;
			end
			S_CLR_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = node_q;
				ram_wdata = clr_val;
				if (sweep_end)
					state_d = from_item_q ? S_DONE : S_IDLE;
				else if (lvl_last)
					state_d = S_CLR_RSTART;
			end
			S_A_ROOT: begin
				ram_raddr_a = NODE_W'(1);
				state_d     = S_A_ROOTCHK;
			end
			S_A_ROOTCHK: begin
				if (ORD_W'(ram_rdata_a) < req_q)
					state_d = S_DONE;
				else if (lv_ext > req_q)
					state_d = S_A_DRD;
				else
					state_d = S_A_OFF;
			end
			S_A_DRD: begin
				ram_raddr_a = l_idx;
				ram_raddr_b = l_idx | NODE_W'(1);
				state_d     = S_A_DDEC;
			end
			S_A_DDEC: begin
				state_d = (ORD_W'(ord_q) - ORD_W'(1) > req_q) ? S_A_DRD : S_A_OFF;
			end
			S_A_OFF: state_d = S_A_CHK;
			S_A_CHK: begin
				if (align_bad)
					state_d = S_DONE;
				else begin
					ram_we    = 1'b1;
					ram_waddr = block_q;
					ram_wdata = '0;
					state_d   = (req_q < lv_ext) ? S_A_URD : S_DONE;
				end
			end
			S_A_URD: begin
				ram_raddr_a = block_q ^ NODE_W'(1);
				ram_raddr_b = block_q >> 1;
				state_d     = S_A_UDEC;
			end
			S_A_UDEC: begin
				if (ram_rdata_b == climb_cap)
					state_d = S_DONE;
				else begin
					ram_we    = 1'b1;
					ram_waddr = block_q >> 1;
					ram_wdata = climb_cap;
					state_d   = (ord_inc < lv_q) ? S_A_URD : S_DONE;
				end
			end
			S_F_IDX: state_d = (req_q > lv_ext) ? S_DONE : S_F_CHK;
			S_F_CHK: begin
				if (idx_q >= free_lim)
					state_d = S_DONE;
				else begin
					ram_we    = 1'b1;
					ram_waddr = free_block;
					ram_wdata = req_c;
					state_d   = (req_q < lv_ext) ? S_F_RD : S_DONE;
				end
			end
			S_F_RD: begin
				ram_raddr_a = block_q ^ NODE_W'(1);
				state_d     = S_F_DEC;
			end
			S_F_DEC: begin
				if (buddy_ge && cap_q < ord_q)
					state_d = S_DONE;
				else begin
					ram_we    = 1'b1;
					ram_waddr = block_q >> 1;
					ram_wdata = merge_cap;
					state_d   = (ord_inc < lv_q) ? S_F_RD : S_DONE;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			from_item_q <= 1'b0;
		else if (state_q == S_IDLE && in_valid)
			from_item_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					item_q   <= in_item;
					status_q <= ST_OK;
					boff_q   <= '0;
				end
			end
			S_ORD_WAIT: begin
				if (bl_done)
					req_q <= item_ord;
			end
			S_CLR_START: begin
				cbo_q <= cfg.base_order;
				sh_q  <= cfg.region_bytes >> cfg.base_order;
			end
			S_CLR_LV: begin
				if (bl_done)
					lv_q <= clr_lv;
			end
			S_CLR_BLK: begin
				blocks_q <= (sh_q > lv_pow) ? lv_pow[NODE_W-1:0] : sh_q[NODE_W-1:0];
				node_q   <= NODE_W'(1);
				i_q      <= '0;
				o_q      <= lv_q;
				act_q    <= 1'b1;
			end
			S_CLR_RSTART: begin
				if (act_q)
					full_q <= blocks_q >> (o_q - CAP_W'(1));
				else
					full_q <= '0;
			end
			S_CLR_RWAIT: begin
				if (bl_done)
					r_q <= bl_len[CAP_W-1:0];
			end
			S_CLR_SWEEP: begin
				node_q <= node_q + NODE_W'(1);
				if (lvl_last) begin
					i_q <= '0;
					if (o_q == CAP_W'(1))
						act_q <= 1'b0;
					else
						o_q <= o_q - CAP_W'(1);
				end else
					i_q <= i_q + NODE_W'(1);
			end
			S_A_ROOTCHK: begin
				if (ORD_W'(ram_rdata_a) < req_q)
					status_q <= ST_OOM;
				block_q <= NODE_W'(1);
				ord_q   <= lv_q;
			end
			S_A_DDEC: begin
				block_q <= desc_block;
				ord_q   <= ord_q - CAP_W'(1);
			end
			S_A_OFF: off_q <= 32'(blk_in_lvl) << sh_amt;
			S_A_CHK: begin
				if (align_bad)
					status_q <= ST_ALIGN;
				else
					boff_q <= off_q;
				cap_q <= '0;
				ord_q <= req_c;
			end
			S_A_UDEC: begin
				cap_q   <= climb_cap;
				block_q <= block_q >> 1;
				ord_q   <= ord_inc;
			end
			S_F_IDX: idx_q <= item_q.offset >> sh_amt;
			S_F_CHK: begin
				block_q <= free_block;
				cap_q   <= req_c;
				ord_q   <= req_c;
			end
			S_F_DEC: begin
				cap_q   <= merge_cap;
				block_q <= block_q >> 1;
				ord_q   <= ord_inc;
			end
			default: ;
		endcase
	end

	assign res.block_offset = boff_q;
	assign res.status       = status_q;

`ifndef NO_ASSERTIONS
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("tree written while idle");

	a_wr_within_levels: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_wdata <= lv_q))
		else $error("tree entry above root order");

	a_bitlen_expected: assert property (@(posedge clk) disable iff (!arst_n)
		bl_done |-> (state_q == S_ORD_WAIT || state_q == S_CLR_LV || state_q == S_CLR_RWAIT))
		else $error("bit length result with nobody waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result changed before it was taken");
`endif

endmodule

`default_nettype wire

>>> src/buddy_allocator_tree_core.sv
`timescale 1ns / 1ps
// run time: allocate grows with the levels descended and climbed, free with the
//   levels merged, and clear with the number of tree nodes swept
// throughput: one item at a time; the next item is taken once the result sits in
//   the output register
// reset: async active low, then runs a clearing pass with s_axis_tready low;
//   configuration writes are taken as ever
`default_nettype none

module buddy_allocator_tree_core import bat_pkg::*; #(
	parameter int MAX_LEAVES = MAX_LEAVES_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// request items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [95:0] s_axis_tdata,   // num_bytes, align, offset
	input  wire  [1:0]  s_axis_tuser,   // mode
	// result items
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // block_offset
	output logic [1:0]  m_axis_tuser,   // status
	// register writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);

	cfg_t  cfg_q;
	item_t in_item;
	logic  res_valid;
	logic  res_ready;
	res_t  res;
	logic  out_valid_q;
	res_t  out_q;

	// registers are always writable; region_bytes acts at the next clear, base_order and region_base also on later items
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_bytes <= RST_REGION_BYTES;
			cfg_q.base_order   <= RST_BASE_ORDER;
			cfg_q.region_base  <= RST_REGION_BASE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_REGION_BYTES: cfg_q.region_bytes <= cfg_data;
				REG_BASE_ORDER:   cfg_q.base_order   <= cfg_data[4:0];
				REG_REGION_BASE:  cfg_q.region_base  <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// unpack the request item
	assign in_item.mode      = mode_t'(s_axis_tuser);
	assign in_item.num_bytes = s_axis_tdata[31:0];
	assign in_item.align     = s_axis_tdata[63:32];
	assign in_item.offset    = s_axis_tdata[95:64];

	bat_ctrl #(
		.MAX_LEAVES (MAX_LEAVES),
		.MAX_LEVELS (MAX_LEVELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register parts the sequencer from the downstream stall
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.block_offset;
	assign m_axis_tuser  = out_q.status;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for buddy_allocator_tree_core: a directed table, then phases of random
// allocate and free traffic under several register settings, checked against a local predictor
// depends on bat_pkg (modes, status codes, register indexes, item types) and the core itself

module testbench;
	import bat_pkg::*;

	localparam int TREE_NODES = 2 * MAX_LEAVES_DEF;
	// slowest item is a clear, which sweeps every tree node, plus both stalls;
	// the limit allows that several times over for every item of the run
	localparam longint CYCLE_LIMIT = 64'd12_000_000;
	localparam int BACKLOG_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int NUM_DIRECTED = 25;
	localparam int NUM_PHASES = 6;

	typedef struct packed {
		item_t req;
		logic  typed;
		res_t  want;
	} dir_row_t;

	typedef struct {
		logic [31:0] offset;
		logic [31:0] nbytes;
	} live_block_t;

	typedef struct {
		logic [31:0] region_bytes;
		logic [4:0]  base_order;
		logic [31:0] region_base;
		int          items;
		bit          clear_first;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [95:0] s_axis_tdata;     // num_bytes, align, offset
	logic [1:0]  s_axis_tuser;     // mode
	wire         m_axis_tvalid;
	logic        m_axis_tready;
	wire  [31:0] m_axis_tdata;     // block_offset
	wire  [1:0]  m_axis_tuser;     // status
	logic        cfg_valid;
	wire         cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor state: capacity per tree node, root order and the register copy
	logic [3:0]  model_caps [TREE_NODES];
	int unsigned model_levels;
	cfg_t        model_cfg;

	res_t        pending_results [$];
	live_block_t live_blocks [$];
	dir_row_t    directed_rows [NUM_DIRECTED];
	phase_t      phases [NUM_PHASES];

	bit          quiet_mode;
	bit          backlog_req;
	longint      cycle_count;
	int          mismatches;
	int          n_clears, n_placed, n_oom, n_misaligned, n_frees, n_settings;

	buddy_allocator_tree_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic int unsigned bit_length(longint unsigned v);
		int unsigned n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	// order of a size: ceil(log2 n) - base_order + 1, never below one; zero wraps to all ones
	function automatic int unsigned size_order(logic [31:0] n);
		logic [31:0] nm1;
		int unsigned bw;
		nm1 = n - 32'd1;
		bw = bit_length({32'd0, nm1});
		return (bw <= model_cfg.base_order) ? 1 : bw - model_cfg.base_order + 1;
	endfunction

	// wipe the tree, then lay out full blocks per level and the partial one at the end
	function automatic void rebuild_free_layout();
		int unsigned lim, r;
		longint unsigned blocks, row_base, full, rem;
		lim = MAX_LEVELS_DEF;
		while (lim > 1 && (64'd1 << (lim - 1)) > 64'(MAX_LEAVES_DEF))
			lim--;
		blocks = {32'd0, model_cfg.region_bytes} >> model_cfg.base_order;
		model_levels = size_order(model_cfg.region_bytes);
		if (model_levels > lim)
			model_levels = lim;
		// oversized region saturates at the root block
		if (blocks > (64'd1 << (model_levels - 1)))
			blocks = 64'd1 << (model_levels - 1);
		foreach (model_caps[k])
			model_caps[k] = '0;
		row_base = 1;
		for (int o = model_levels; o > 0; o--) begin
			full = blocks >> (o - 1);
			rem = blocks - (full << (o - 1));
			r = bit_length(rem);
			for (longint unsigned i = 0; i < full; i++)
				model_caps[row_base + i] = 4'(o);
			if (r != 0)
				model_caps[row_base + full] = 4'(r);
			row_base = row_base * 2;
		end
	endfunction

	function automatic res_t predict_alloc(logic [31:0] nbytes, logic [31:0] align);
		int unsigned req, o;
		longint unsigned blk, lft, off;
		logic [31:0] addr;
		logic [3:0] cap;
		res_t res;
		res.block_offset = '0;
		res.status = ST_OK;
		req = size_order(nbytes);
		if (model_caps[1] < req) begin
			res.status = ST_OOM;
			return res;
		end
		// walk down, taking the smaller child that still fits
		blk = 1;
		for (o = model_levels; o > req; o--) begin
			lft = blk * 2;
			if (model_caps[lft] < model_caps[lft + 1])
				blk = lft + ((model_caps[lft] < req) ? 1 : 0);
			else
				blk = lft + ((model_caps[lft + 1] >= req) ? 1 : 0);
		end
		off = (blk - (64'd1 << (model_levels - req))) << (model_cfg.base_order + req - 1);
		addr = model_cfg.region_base + off[31:0];
		// align of zero gives a mask of all ones
		if ((addr & (align - 32'd1)) != 32'd0) begin
			res.status = ST_ALIGN;
			return res;
		end
		model_caps[blk] = '0;
		cap = '0;
		for (o = req; o < model_levels; o++) begin
			if (model_caps[blk ^ 1] > cap)
				cap = model_caps[blk ^ 1];
			if (model_caps[blk / 2] == cap)
				break;
			model_caps[blk / 2] = cap;
			blk = blk / 2;
		end
		res.block_offset = off[31:0];
		return res;
	endfunction

	// returns zero when the free lies outside the tree and is dropped
	function automatic bit predict_free(logic [31:0] nbytes, logic [31:0] offset);
		int unsigned o, c, buddy;
		longint unsigned idx, blk;
		o = size_order(nbytes);
		if (o > model_levels)
			return 1'b0;
		idx = {32'd0, offset} >> (model_cfg.base_order + o - 1);
		if (idx >= (64'd1 << (model_levels - o)))
			return 1'b0;
		blk = (64'd1 << (model_levels - o)) + idx;
		c = o;
		model_caps[blk] = 4'(c);
		// merge buddies while both halves are wholly free, then raise the parents' capacity
		while (o < model_levels) begin
			buddy = model_caps[blk ^ 1];
			if (buddy >= c) begin
				if (c < o)
					break;
				c++;
			end
			blk = blk / 2;
			model_caps[blk] = 4'(c);
			o++;
		end
		return 1'b1;
	endfunction

	function automatic res_t predict_item(input item_t req, output bit acted);
		res_t res;
		res.block_offset = '0;
		res.status = ST_OK;
		acted = 1'b1;
		case (req.mode)
			MODE_CLEAR: begin
				rebuild_free_layout();
				n_clears++;
			end
			MODE_ALLOC: begin
				res = predict_alloc(req.num_bytes, req.align);
				case (res.status)
					ST_OK:    n_placed++;
					ST_OOM:   n_oom++;
					default:  n_misaligned++;
				endcase
			end
			MODE_FREE: begin
				acted = predict_free(req.num_bytes, req.offset);
				if (acted)
					n_frees++;
			end
			default: acted = 1'b0;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// random request generation
	// ------------------------------------------------------------------

	// size spread over every order the current setting knows, small ones as likely as large
	function automatic logic [31:0] rand_size();
		int unsigned e;
		longint unsigned span;
		e = $urandom_range(0, model_cfg.base_order + model_levels);
		if (e >= 32)
			return $urandom;
		span = 64'd1 << e;
		return 32'(({32'd0, $urandom} % span) + 1);
	endfunction

	function automatic logic [31:0] rand_align();
		int unsigned e;
		e = $urandom_range(0, model_cfg.base_order + 6);
		if (e > 31 || $urandom_range(0, 19) == 0)
			e = 31;
		return 32'd1 << e;
	endfunction

	// mostly allocations and frees of live blocks, the rest noise
	function automatic item_t random_request();
		item_t req;
		int unsigned pick, k;
		req.mode = MODE_ALLOC;
		req.num_bytes = rand_size();
		req.align = rand_align();
		req.offset = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			req.mode = MODE_CLEAR;
		end else if (pick >= 52 && pick < 88) begin
			if (live_blocks.size() != 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				req.mode = MODE_FREE;
				req.num_bytes = live_blocks[k].nbytes;
				req.offset = live_blocks[k].offset;
				live_blocks.delete(k);
			end
		end else if (pick >= 88 && pick < 94) begin
			// free with made-up offset and size, often out of range
			req.mode = MODE_FREE;
			req.offset = $urandom >> $urandom_range(0, 31);
		end else if (pick >= 94 && pick < 97) begin
			req.num_bytes = $urandom;
			req.align = $urandom;
		end else if (pick >= 97) begin
			req.mode = MODE_NOP;
		end
		return req;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// offer one item, wait for it to be taken, then book its expected result
	task automatic offer_item(input item_t req, input bit typed, input res_t want,
			output res_t got, output bit acted);
		res_t pred;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {req.offset, req.align, req.num_bytes};
		s_axis_tuser <= req.mode;
		do @(posedge clk); while (!s_axis_tready);
		pred = predict_item(req, acted);
		pending_results.push_back(typed ? want : pred);
		got = pred;
		// sender idle burst
		if (!quiet_mode && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_REGION_BYTES: model_cfg.region_bytes = val;
			REG_BASE_ORDER:   model_cfg.base_order = val[4:0];
			REG_REGION_BASE:  model_cfg.region_base = val;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		item_t req;
		res_t got, none;
		bit acted;
		int effective;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		quiet_mode = 1'b0;
		backlog_req = 1'b0;
		none = '0;

		// reset loads register defaults and runs a clear
		model_cfg.region_bytes = RST_REGION_BYTES;
		model_cfg.base_order = RST_BASE_ORDER;
		model_cfg.region_base = RST_REGION_BASE;
		rebuild_free_layout();

		// default setting: 1024 leaves of 64 bytes, eleven levels
		directed_rows = '{
			'{'{MODE_ALLOC, 32'd65536,      32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd1,          32'd1,          32'd0},      1'b1, '{32'd0, ST_OOM}},
			'{'{MODE_FREE,  32'd65536,      32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd0,          32'd1,          32'd0},      1'b1, '{32'd0, ST_OOM}},
			'{'{MODE_ALLOC, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0},      1'b1, '{32'd0, ST_OOM}},
			'{'{MODE_ALLOC, 32'd65537,      32'd1,          32'd0},      1'b1, '{32'd0, ST_OOM}},
			'{'{MODE_ALLOC, 32'd1,          32'h8000_0000,  32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd1,          32'd0,          32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd64,         32'd1,          32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd65,         32'd128,        32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd4096,       32'd4096,       32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd100,        32'd3,          32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_FREE,  32'd64,         32'd1,          32'hFFFF_FFFF}, 1'b1, '{32'd0, ST_OK}},
			'{'{MODE_FREE,  32'hFFFF_FFFF,  32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_FREE,  32'd0,          32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_NOP,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF}, 1'b1, '{32'd0, ST_OK}},
			'{'{MODE_FREE,  32'd4096,       32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_FREE,  32'd65,         32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_CLEAR, 32'd0,          32'd0,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd32768,      32'd32768,      32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd32768,      32'd1,          32'd0},      1'b0, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd1,          32'd1,          32'd0},      1'b1, '{32'd0, ST_OOM}},
			'{'{MODE_FREE,  32'd32768,      32'd1,          32'd32768},  1'b1, '{32'd0, ST_OK}},
			'{'{MODE_FREE,  32'd32768,      32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}},
			'{'{MODE_ALLOC, 32'd65536,      32'd1,          32'd0},      1'b1, '{32'd0, ST_OK}}
		};

		// register settings per phase: default, one byte, largest region with base order 24,
		// a partial region, an oversized one, and a last change left without a clear
		phases[0] = '{32'd65536,       5'd6,  32'd0,           520, 1'b1};
		phases[1] = '{32'd1,           5'd0,  32'hFFFF_FFFF,   40,  1'b1};
		phases[2] = '{32'hFFFF_FFFF,   5'd24, 32'h1234_5600,   260, 1'b1};
		phases[3] = '{32'd1000,        5'd3,  32'h0000_0040,   300, 1'b1};
		phases[4] = '{32'd100000,      5'd4,  32'h0003_F000,   300, 1'b1};
		phases[5] = '{32'd4096,        5'd5,  32'd0,           180, 1'b0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; tready stays low through the clearing pass after reset
		for (int i = 0; i < NUM_DIRECTED; i++)
			offer_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want,
				got, acted);
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			// block is idle here: every result is back and items always give one
			write_reg(REG_REGION_BYTES, phases[p].region_bytes);
			write_reg(REG_BASE_ORDER, {27'd0, phases[p].base_order});
			write_reg(REG_REGION_BASE, phases[p].region_base);
			cfg_valid <= 1'b0;
			n_settings++;
			// last phase runs with no idling on either side
			quiet_mode = (p == NUM_PHASES - 1);
			if (phases[p].clear_first) begin
				req = '0;
				req.mode = MODE_CLEAR;
				offer_item(req, 1'b0, none, got, acted);
				live_blocks.delete();
			end
			effective = 0;
			while (effective < phases[p].items) begin
				// one long receiver hold early on, so the core backs up into its input
				if (p == 0 && effective == 20)
					backlog_req = 1'b1;
				req = random_request();
				offer_item(req, 1'b0, none, got, acted);
				if (req.mode == MODE_CLEAR)
					live_blocks.delete();
				else if (req.mode == MODE_ALLOC && got.status == ST_OK)
					live_blocks.push_back('{got.block_offset, req.num_bytes});
				if (acted)
					effective++;
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d clears, %0d blocks placed, %0d out of memory, %0d misaligned,",
			n_clears, n_placed, n_oom, n_misaligned);
		$display("%0d frees under %0d register settings; %0d mismatches in %0d cycles",
			n_frees, n_settings, mismatches, cycle_count);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random stall bursts, plus the one long hold on request
	// ------------------------------------------------------------------

	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (backlog_req) begin
				backlog_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	function automatic void log_mismatch(string what, logic [31:0] want, logic [31:0] seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, seen);
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				log_mismatch("result with none pending (block_offset)", 32'd0, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata !== want.block_offset)
					log_mismatch("block_offset", want.block_offset, m_axis_tdata);
				if (m_axis_tuser !== want.status)
					log_mismatch("status", {30'd0, want.status}, {30'd0, m_axis_tuser});
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
